### rtl/pal_pkg.sv
`default_nettype none

package pal_pkg;

   // Operation codes carried in the kind field. Code 3 is decoded as get.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_GET    = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [7:0]         count;
   } rsp_type;

   // Memory read address sources.
   typedef enum logic [1:0] {
      RD_POS    = 2'd0,
      RD_IDX_M1 = 2'd1,
      RD_IDX    = 2'd2
   } rd_sel_type;

   // Memory write address and data sources.
   typedef enum logic [1:0] {
      WR_NEW_AT_POS = 2'd0,
      WR_UP_AT_IDX  = 2'd1,
      WR_DOWN_AT_M1 = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       set_status;
      logic       idx_from_count;
      logic       idx_from_pos;
      logic       idx_dec;
      logic       idx_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       save_word;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_delete;
      logic range_err;
      logic full_err;
      logic idx_at_pos;
      logic idx_at_end;
   } stat_type;

endpackage

`default_nettype wire

### rtl/positional_array_list_core.sv
// Ordered list of up to CAPACITY signed 32-bit words kept in a single-port
// style memory (one write and one registered read per cycle). Each request
// word carries insert, delete or get together with a position; each request
// yields exactly one response word with a status, the word read and the new
// entry count. The block works on one request at a time. A get passes
// through the decide and read-wait states to the finish state, which loads
// the response register, and a request that fails its position or capacity
// check goes from decide straight to finish. An insert moves the entries
// from the end down to position p up by one, and a delete saves the word at
// p and moves the entries above it down by one; each move is a memory read
// followed by a write of the registered read data. A finished response
// waits in an output register, so the next request is accepted while the
// previous response is still held. The count clears at reset; the memory
// needs no clearing because only entries below the count are ever read.
`default_nettype none

module positional_array_list_core
   import pal_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences each operation and owns both handshakes.
   pal_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the list memory, the count, the shift index and the
   // response register.
   pal_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

   // Only one request is in flight, so a request is never taken in the
   // cycle right after another one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // A failed request returns a zero word. Inserts also return zero, but only failures are checked.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status != STATUS_DONE)) |-> (rsp_word.read_value == '0))
      else $error("failed response carries a nonzero word");

   // A full report only happens when the list holds CAPACITY entries.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == STATUS_FULL)) |-> (rsp_word.count == 8'(CAPACITY)))
      else $error("full status with a count below capacity");

endmodule

`default_nettype wire

### rtl/pal_datapath.sv
`default_nettype none

module pal_datapath
   import pal_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_word,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output rsp_type      rsp_word
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (IW > 8) ? IW : 8;

   logic [31:0] mem [CAPACITY];

   req_type     req_ff;
   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0] rd_data_ff;
   logic [31:0] word_ff;
   logic [1:0]  status_ff;
   rsp_type     rsp_ff;

   logic [CW-1:0] pos_ext, count_ext, idx_ext;
   logic [IW-1:0] idx_m1;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;
   logic [1:0]    status_in;

   assign pos_ext   = CW'(req_ff.position);
   assign count_ext = CW'(count_ff);
   assign idx_ext   = CW'(idx_ff);
   assign idx_m1    = idx_ff - IW'(1);

   assign stat.is_insert  = (req_ff.kind == KIND_INSERT);
   assign stat.is_delete  = (req_ff.kind == KIND_DELETE);
   assign stat.range_err  = stat.is_insert ? (pos_ext > count_ext) : (pos_ext >= count_ext);
   assign stat.full_err   = (count_ff == IW'(CAPACITY));
   assign stat.idx_at_pos = (idx_ext == pos_ext);
   assign stat.idx_at_end = (idx_ff == count_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    rd_addr = AW'(req_ff.position);
         RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
         RD_IDX:    rd_addr = idx_ff[AW-1:0];
         default:   rd_addr = idx_ff[AW-1:0];
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_NEW_AT_POS: begin
            wr_addr = AW'(req_ff.position);
            wr_data = req_ff.value;
         end
         WR_UP_AT_IDX: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         WR_DOWN_AT_M1: begin
            wr_addr = idx_m1[AW-1:0];
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      if (stat.range_err) begin
         status_in = STATUS_RANGE;
      end else if (stat.is_insert && stat.full_err) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_DONE;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_from_count) begin
         idx_in = count_ff;
      end else if (cmd.idx_from_pos) begin
         idx_in = IW'(req_ff.position) + IW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + IW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         req_ff  <= req_word;
         word_ff <= '0;
      end else if (cmd.save_word) begin
         word_ff <= rd_data_ff;
      end
      if (cmd.set_status) begin
         status_ff <= status_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.read_value <= word_ff;
         rsp_ff.count      <= 8'(count_ff);
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

### rtl/pal_controller.sv
`default_nettype none

module pal_controller
   import pal_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DECIDE   = 8'b0000_0010,
      ST_INS_CHK  = 8'b0000_0100,
      ST_INS_WR   = 8'b0000_1000,
      ST_GET_WAIT = 8'b0001_0000,
      ST_DEL_CHK  = 8'b0010_0000,
      ST_DEL_WR   = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_POS;
      cmd.wr_sel = WR_NEW_AT_POS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.set_status = 1'b1;
            if (stat.range_err || (stat.is_insert && stat.full_err)) begin
               state_in = ST_FINISH;
            end else if (stat.is_insert) begin
               cmd.idx_from_count = 1'b1;
               state_in           = ST_INS_CHK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_POS;
               state_in   = ST_GET_WAIT;
            end
         end
         ST_INS_CHK: begin
            if (stat.idx_at_pos) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_NEW_AT_POS;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_UP_AT_IDX;
            cmd.idx_dec = 1'b1;
            state_in    = ST_INS_CHK;
         end
         ST_GET_WAIT: begin
            cmd.save_word = 1'b1;
            if (stat.is_delete) begin
               cmd.idx_from_pos = 1'b1;
               state_in         = ST_DEL_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DEL_CHK: begin
            if (stat.idx_at_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_DOWN_AT_M1;
            cmd.idx_inc = 1'b1;
            state_in    = ST_DEL_CHK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
